// ===== sv/rlse_pkg.sv =====
// ----------------------------------------------------------------------------
// rlse_pkg
// Shared types, codes and helpers for the register list stack engine.
// ----------------------------------------------------------------------------
package rlse_pkg;

  // Default sizes
  localparam int STACK_WORDS_DEF = 64;
  localparam int REG_COUNT_DEF   = 16;

  // Register 13 is the stack pointer
  localparam logic [3:0] SP_REG = 4'd13;

  // Registers a push or pop list may not name
  localparam logic [15:0] PUSH_FORBIDDEN = 16'h9F00;
  localparam logic [15:0] POP_FORBIDDEN  = 16'h5F00;

  // Stack pointer limit for the pre-decrement
  localparam logic [31:0] SP_LIMIT = 32'd255;

  // Operation codes
  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_PUSH  = 3'd2,
    OP_POP   = 3'd3,
    OP_IPUSH = 3'd4,
    OP_IPOP  = 3'd5
  } op_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Number of set bits in a 16-bit register list
  function automatic logic [4:0] popcount16(input logic [15:0] m);
    logic [2:0] n0;
    logic [2:0] n1;
    logic [2:0] n2;
    logic [2:0] n3;
    n0 = 3'(m[0])  + 3'(m[1])  + 3'(m[2])  + 3'(m[3]);
    n1 = 3'(m[4])  + 3'(m[5])  + 3'(m[6])  + 3'(m[7]);
    n2 = 3'(m[8])  + 3'(m[9])  + 3'(m[10]) + 3'(m[11]);
    n3 = 3'(m[12]) + 3'(m[13]) + 3'(m[14]) + 3'(m[15]);
    return 5'(n0) + 5'(n1) + 5'(n2) + 5'(n3);
  endfunction

endpackage

// ===== sv/rlse_ram.sv =====
// ----------------------------------------------------------------------------
// rlse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rlse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/register_list_stack_engine.sv =====
// Sequence: setup, then for list operations a scan over the listed registers
//   (plus the flags word for the interrupt forms), then finish, which registers the result.
// A new transaction is taken only in idle, once the last result is registered;
//   during the scan each memory moves one word per cycle through its single write port.
// Reset: control state clears; register file reads zero and stack memory
//   reads all ones through per-entry valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
// register_list_stack_engine
// Register file plus word stack with list push/pop and interrupt frames.
// ----------------------------------------------------------------------------
module register_list_stack_engine #(
  parameter int STACK_WORDS = rlse_pkg::STACK_WORDS_DEF,
  parameter int REG_COUNT   = rlse_pkg::REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  operation,
  input  logic [3:0]  reg_index,
  input  logic [31:0] reg_value,
  input  logic [15:0] reg_mask,
  input  logic [3:0]  flags_in,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] read_value,
  output logic [31:0] stack_pointer,
  output logic [3:0]  flags_out,
  output logic        flags_valid,
  output logic        list_rejected,
  output logic        address_fault
);

  localparam int SW_AW   = $clog2(STACK_WORDS);
  localparam int RF_AW   = $clog2(REG_COUNT);
  localparam int SW_LAST = STACK_WORDS - 2;

  rlse_pkg::state_t state, state_next;

  // Captured transaction
  rlse_pkg::op_t op_q;
  logic [3:0]    ri_q;
  logic [31:0]   val_q;
  logic [15:0]   mask_q;
  logic [3:0]    fin_q;
  logic [6:0]    delta_q;
  logic          is_store;
  logic          is_irq;

  // Working state
  logic [31:0]   sp;
  logic [7:0]    addr;
  logic          rej_q;
  logic          fault_q;
  logic [3:0]    fout_q;
  logic          fval_q;
  logic          flag_done;
  logic          rd_valid_q;
  logic [REG_COUNT-1:0]   rf_vld;
  logic [STACK_WORDS-1:0] st_vld;

  // Second stage: memory read in flight, write back next cycle
  logic             s1_valid;
  logic             s1_ok;
  logic             s1_flag;
  logic [3:0]       s1_reg;
  logic [SW_AW-1:0] s1_widx;
  logic             s1_rvalid;

  // Memory ports
  logic             rf_we, rf_re;
  logic [RF_AW-1:0] rf_waddr, rf_raddr;
  logic [31:0]      rf_wdata, rf_rdata;
  logic             st_we, st_re;
  logic [31:0]      st_wdata, st_rdata;

  // Control strobes
  logic        accept;
  logic        fin_go;
  logic        setup_rej;
  logic        setup_dec;
  logic        is_list;
  logic        iss_any, iss_flag, iss;
  logic [3:0]  iss_reg;
  logic        in_range;
  logic [7:0]  wtmp;
  logic [SW_AW-1:0] widx;
  logic        ld;
  logic [31:0] ld_data;
  logic [31:0] sp_final;
  logic [31:0] rd_final;

  rlse_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (rf_re),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  rlse_ram #(.WIDTH(32), .DEPTH(STACK_WORDS)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (s1_widx),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (widx),
    .rdata (st_rdata)
  );

  // Lowest listed register and word index of the current address
  always_comb begin
    iss_reg = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (mask_q[i]) begin
        iss_reg = 4'(i);
      end
    end
    in_range = {2'b00, addr[7:2]} <= 8'(SW_LAST);
    wtmp     = 8'(SW_LAST) - {2'b00, addr[7:2]};
    widx     = wtmp[SW_AW-1:0];
  end

  // Decode of the captured operation
  always_comb begin
    setup_rej = 1'b0;
    setup_dec = 1'b0;
    is_list   = 1'b0;
    unique case (op_q)
      rlse_pkg::OP_PUSH: begin
        setup_rej = |(mask_q & rlse_pkg::PUSH_FORBIDDEN);
        setup_dec = sp >= rlse_pkg::SP_LIMIT;
        is_list   = 1'b1;
      end
      rlse_pkg::OP_POP: begin
        setup_rej = |(mask_q & rlse_pkg::POP_FORBIDDEN);
        is_list   = 1'b1;
      end
      rlse_pkg::OP_IPUSH: begin
        setup_dec = sp > rlse_pkg::SP_LIMIT;
        is_list   = 1'b1;
      end
      rlse_pkg::OP_IPOP: begin
        is_list   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Final stack pointer and read result
  always_comb begin
    sp_final = sp;
    if (!rej_q) begin
      case (op_q) inside
        rlse_pkg::OP_PUSH, rlse_pkg::OP_IPUSH: sp_final = sp - {25'd0, delta_q};
        rlse_pkg::OP_POP, rlse_pkg::OP_IPOP:   sp_final = sp + {25'd0, delta_q};
        default:                               sp_final = sp;
      endcase
    end
    rd_final = 32'd0;
    if (op_q == rlse_pkg::OP_READ) begin
      if (ri_q == rlse_pkg::SP_REG) begin
        rd_final = sp;
      end else if (rd_valid_q) begin
        rd_final = rf_rdata;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rlse_pkg::ST_IDLE:   if (accept) state_next = rlse_pkg::ST_SETUP;
      rlse_pkg::ST_SETUP:  state_next = (is_list && !setup_rej) ? rlse_pkg::ST_SCAN
                                                                : rlse_pkg::ST_FINISH;
      rlse_pkg::ST_SCAN:   if (!iss) state_next = rlse_pkg::ST_FINISH;
      rlse_pkg::ST_FINISH: if (fin_go) state_next = rlse_pkg::ST_IDLE;
      default:             state_next = rlse_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer and memory port control
  always_comb begin
    item_stall = (state != rlse_pkg::ST_IDLE);
    accept     = item_valid && (state == rlse_pkg::ST_IDLE);
    fin_go     = (state == rlse_pkg::ST_FINISH) && (!result_valid || !result_stall);

    iss_any  = |mask_q;
    iss_flag = !iss_any && is_irq && !flag_done;
    iss      = (state == rlse_pkg::ST_SCAN) && (iss_any || iss_flag);

    // register file: read for a register read or a store, write on a register write or a load
    rf_re    = ((state == rlse_pkg::ST_SETUP) && (op_q == rlse_pkg::OP_READ)) ||
               (iss && is_store && iss_any);
    rf_raddr = (state == rlse_pkg::ST_SETUP) ? ri_q[RF_AW-1:0] : iss_reg[RF_AW-1:0];

    ld       = s1_valid && s1_ok && !is_store;
    ld_data  = s1_rvalid ? st_rdata : '1;

    rf_we    = ((state == rlse_pkg::ST_SETUP) && (op_q == rlse_pkg::OP_WRITE)) ||
               (ld && !s1_flag);
    rf_waddr = (state == rlse_pkg::ST_SETUP) ? ri_q[RF_AW-1:0] : s1_reg[RF_AW-1:0];
    rf_wdata = (state == rlse_pkg::ST_SETUP) ? val_q : ld_data;

    // stack memory
    st_re    = iss && !is_store && in_range;
    st_we    = s1_valid && s1_ok && is_store;
    if (s1_flag) begin
      st_wdata = {28'd0, fin_q};
    end else if (s1_reg == rlse_pkg::SP_REG) begin
      st_wdata = sp;
    end else begin
      st_wdata = s1_rvalid ? rf_rdata : 32'd0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rlse_pkg::ST_IDLE;
      result_valid <= 1'b0;
      sp           <= 32'd0;
      rf_vld       <= '0;
      st_vld       <= '0;
      s1_valid     <= 1'b0;
      flag_done    <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= iss;

      if (accept) begin
        flag_done <= 1'b0;
      end else if (iss && !iss_any) begin
        flag_done <= 1'b1;
      end

      // Stack pointer: setup, r13 load, final adjust
      if (state == rlse_pkg::ST_SETUP) begin
        if (op_q == rlse_pkg::OP_WRITE && ri_q == rlse_pkg::SP_REG) begin
          sp <= val_q;
        end else if (setup_dec && !setup_rej) begin
          sp <= sp - 32'd1;
        end
      end else if (ld && !s1_flag && s1_reg == rlse_pkg::SP_REG) begin
        sp <= ld_data;
      end else if (fin_go) begin
        sp <= sp_final;
      end

      if (rf_we) begin
        rf_vld[rf_waddr] <= 1'b1;
      end
      if (st_we) begin
        st_vld[s1_widx] <= 1'b1;
      end

      if (fin_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Transaction capture, address walk and payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= rlse_pkg::op_t'(operation);
      ri_q     <= reg_index;
      val_q    <= reg_value;
      mask_q   <= reg_mask;
      fin_q    <= flags_in;
      is_store <= (operation == rlse_pkg::OP_PUSH) || (operation == rlse_pkg::OP_IPUSH);
      is_irq   <= (operation == rlse_pkg::OP_IPUSH) || (operation == rlse_pkg::OP_IPOP);
      delta_q  <= {rlse_pkg::popcount16(reg_mask), 2'b00} +
                  (((operation == rlse_pkg::OP_IPUSH) || (operation == rlse_pkg::OP_IPOP))
                   ? 7'd4 : 7'd0);
      rej_q    <= 1'b0;
      fault_q  <= 1'b0;
      fout_q   <= 4'd0;
      fval_q   <= 1'b0;
    end

    // Setup: rejection, start address, register read valid
    if (state == rlse_pkg::ST_SETUP) begin
      rej_q      <= setup_rej;
      rd_valid_q <= rf_vld[ri_q[RF_AW-1:0]];
      if (op_q == rlse_pkg::OP_PUSH || op_q == rlse_pkg::OP_IPUSH) begin
        addr <= sp[7:0] - {7'd0, setup_dec} - {1'b0, delta_q};
      end else begin
        addr <= sp[7:0];
      end
    end

    // Issue one list element or the flags word
    if (iss) begin
      addr      <= addr + 8'd4;
      s1_ok     <= in_range;
      s1_flag   <= !iss_any;
      s1_reg    <= iss_reg;
      s1_widx   <= widx;
      s1_rvalid <= is_store ? rf_vld[iss_reg[RF_AW-1:0]]
                            : (in_range && st_vld[widx]);
      if (iss_any) begin
        mask_q <= mask_q & (mask_q - 16'd1);
      end
      if (!in_range) begin
        fault_q <= 1'b1;
      end
    end

    // Restored flags
    if (ld && s1_flag) begin
      fout_q <= ld_data[3:0];
      fval_q <= 1'b1;
    end

    // Result register
    if (fin_go) begin
      read_value    <= rd_final;
      stack_pointer <= sp_final;
      flags_out     <= fout_q;
      flags_valid   <= fval_q;
      list_rejected <= rej_q;
      address_fault <= fault_q;
    end
  end

  // Checks
  a_s1_from_scan: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(state) == rlse_pkg::ST_SCAN)
    else $error("stage one busy outside of list scan");

  a_accept_setup: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> state == rlse_pkg::ST_SETUP)
    else $error("accepted transaction did not enter setup");

  a_flags_ipop: assert property (@(posedge clk) disable iff (rst)
    (state != rlse_pkg::ST_IDLE) && fval_q |-> op_q == rlse_pkg::OP_IPOP)
    else $error("flags restored outside interrupt pop");

  a_rej_no_fault: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(list_rejected && address_fault))
    else $error("rejected list reported an address fault");

  a_no_write_rejected: assert property (@(posedge clk) disable iff (rst)
    (state == rlse_pkg::ST_FINISH) && rej_q |-> !st_we && !rf_we)
    else $error("memory written for a rejected list");

endmodule

// ===== test/rlse_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rlse_checker
// Watches both channels of the register list stack engine. Keeps its own
// register file and stack image, works out the result of every accepted
// transaction and compares the results in order as they leave the block.
// ----------------------------------------------------------------------------
module rlse_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [2:0]  operation,
  input  logic [3:0]  reg_index,
  input  logic [31:0] reg_value,
  input  logic [15:0] reg_mask,
  input  logic [3:0]  flags_in,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [31:0] read_value,
  input  logic [31:0] stack_pointer,
  input  logic [3:0]  flags_out,
  input  logic        flags_valid,
  input  logic        list_rejected,
  input  logic        address_fault,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0] rd;
    logic [31:0] sp;
    logic [3:0]  fl;
    logic        fv;
    logic        rej;
    logic        flt;
  } frame_result_t;

  // shadow state of the block
  logic [31:0] shadow_regs [rlse_pkg::REG_COUNT_DEF];
  logic [31:0] shadow_stack [rlse_pkg::STACK_WORDS_DEF];

  frame_result_t pending_results [$];
  frame_result_t oldest;
  int fail_cnt = 0;
  int pend_cnt = 0;
  int k;

  assign errors      = fail_cnt;
  assign outstanding = pend_cnt;

  // word slot for a byte address; negative means off the bottom of the stack
  function automatic int word_slot(input logic [7:0] addr);
    return rlse_pkg::STACK_WORDS_DEF - (int'(addr >> 2) + 2);
  endfunction

  // move the listed registers to or from the stack, ascending; returns next address
  function automatic logic [7:0] move_list(input logic [15:0] mask, input logic [7:0] addr,
                                           input bit to_regs, inout logic fault);
    logic [7:0] a;
    int slot;
    int i;
    a = addr;
    for (i = 0; i < rlse_pkg::REG_COUNT_DEF; i++) begin
      if (mask[i]) begin
        slot = word_slot(a);
        if (slot < 0) fault = 1'b1;
        else if (to_regs) shadow_regs[i] = shadow_stack[slot];
        else shadow_stack[slot] = shadow_regs[i];
        a = a + 8'd4;
      end
    end
    return a;
  endfunction

  // apply one transaction to the shadow state and return its result
  function automatic frame_result_t apply_op(input logic [2:0] op, input logic [3:0] idx,
                                             input logic [31:0] val, input logic [15:0] mask,
                                             input logic [3:0] fin);
    frame_result_t r;
    logic [31:0] sp;
    logic [31:0] span;
    logic [7:0] nxt;
    logic flt;
    int cnt;
    int slot;
    int i;
    r = '0;
    flt = 1'b0;
    cnt = 0;
    for (i = 0; i < 16; i++) cnt += int'(mask[i]);
    span = 32'(cnt * 4);
    case (op)
      rlse_pkg::OP_WRITE: shadow_regs[idx] = val;
      rlse_pkg::OP_READ: r.rd = shadow_regs[idx];
      rlse_pkg::OP_PUSH: begin
        if (|(mask & rlse_pkg::PUSH_FORBIDDEN)) begin
          r.rej = 1'b1;
        end else begin
          if (shadow_regs[rlse_pkg::SP_REG] >= rlse_pkg::SP_LIMIT)
            shadow_regs[rlse_pkg::SP_REG] = shadow_regs[rlse_pkg::SP_REG] - 32'd1;
          sp = shadow_regs[rlse_pkg::SP_REG];
          nxt = move_list(mask, 8'(sp - span), 1'b0, flt);
          shadow_regs[rlse_pkg::SP_REG] = sp - span;
        end
      end
      rlse_pkg::OP_POP: begin
        if (|(mask & rlse_pkg::POP_FORBIDDEN)) begin
          r.rej = 1'b1;
        end else begin
          nxt = move_list(mask, 8'(shadow_regs[rlse_pkg::SP_REG]), 1'b1, flt);
          // a loaded r13 is the base of the increment
          shadow_regs[rlse_pkg::SP_REG] = shadow_regs[rlse_pkg::SP_REG] + span;
        end
      end
      rlse_pkg::OP_IPUSH: begin
        if (shadow_regs[rlse_pkg::SP_REG] > rlse_pkg::SP_LIMIT)
          shadow_regs[rlse_pkg::SP_REG] = shadow_regs[rlse_pkg::SP_REG] - 32'd1;
        sp = shadow_regs[rlse_pkg::SP_REG];
        nxt = move_list(mask, 8'(sp - span - 32'd4), 1'b0, flt);
        slot = word_slot(nxt);
        if (slot < 0) flt = 1'b1;
        else shadow_stack[slot] = {28'd0, fin};
        shadow_regs[rlse_pkg::SP_REG] = sp - span - 32'd4;
      end
      rlse_pkg::OP_IPOP: begin
        nxt = move_list(mask, 8'(shadow_regs[rlse_pkg::SP_REG]), 1'b1, flt);
        slot = word_slot(nxt);
        if (slot < 0) begin
          flt = 1'b1;
        end else begin
          r.fl = shadow_stack[slot][3:0];
          r.fv = 1'b1;
        end
        shadow_regs[rlse_pkg::SP_REG] = shadow_regs[rlse_pkg::SP_REG] + span + 32'd4;
      end
      default: ;
    endcase
    r.sp  = shadow_regs[rlse_pkg::SP_REG];
    r.flt = flt;
    return r;
  endfunction

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
      fail_cnt++;
    end
  endtask

  // compare departing results, then record the accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      for (k = 0; k < rlse_pkg::REG_COUNT_DEF; k++) shadow_regs[k] = '0;
      for (k = 0; k < rlse_pkg::STACK_WORDS_DEF; k++) shadow_stack[k] = '1;
      pending_results.delete();
      pend_cnt = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual sp=%h rd=%h", $time,
                   stack_pointer, read_value);
          fail_cnt++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("read_value", oldest.rd, read_value);
          check_field("stack_pointer", oldest.sp, stack_pointer);
          check_field("flags_out", 32'(oldest.fl), 32'(flags_out));
          check_field("flags_valid", 32'(oldest.fv), 32'(flags_valid));
          check_field("list_rejected", 32'(oldest.rej), 32'(list_rejected));
          check_field("address_fault", 32'(oldest.flt), 32'(address_fault));
        end
      end
      if (item_valid && !item_stall)
        pending_results.push_back(apply_op(operation, reg_index, reg_value, reg_mask,
                                           flags_in));
      pend_cnt = pending_results.size();
    end
  end

endmodule

// ===== test/tb_register_list_stack_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_register_list_stack_engine
// Drives register reads and writes, list pushes and pops and interrupt
// frames into the engine: a directed opening, then random traffic with
// idle bursts on both channels and one long result hold-off. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_register_list_stack_engine;

  // codes with no operation behind them
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS   = 1830;
  localparam int CALM_ITEMS     = 200;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int DRAIN_CYCLES   = 30;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [2:0]  operation;
  logic [3:0]  reg_index;
  logic [31:0] reg_value;
  logic [15:0] reg_mask;
  logic [3:0]  flags_in;
  logic        result_valid;
  logic        result_stall;
  logic [31:0] read_value;
  logic [31:0] stack_pointer;
  logic [3:0]  flags_out;
  logic        flags_valid;
  logic        list_rejected;
  logic        address_fault;

  int errors;
  int outstanding;
  bit tx_gaps   = 1'b0;
  bit rx_gaps   = 1'b0;
  bit hold_req  = 1'b0;

  register_list_stack_engine uut (
    .clk, .rst,
    .item_valid, .item_stall, .operation, .reg_index, .reg_value, .reg_mask, .flags_in,
    .result_valid, .result_stall, .read_value, .stack_pointer, .flags_out, .flags_valid,
    .list_rejected, .address_fault
  );

  rlse_checker chk (
    .clk, .rst,
    .item_valid, .item_stall, .operation, .reg_index, .reg_value, .reg_mask, .flags_in,
    .result_valid, .result_stall, .read_value, .stack_pointer, .flags_out, .flags_valid,
    .list_rejected, .address_fault,
    .errors, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // offer one transaction and hold it until accepted, then maybe idle
  task automatic send_item(input logic [2:0] op, input logic [3:0] idx,
                           input logic [31:0] val, input logic [15:0] mask,
                           input logic [3:0] fin);
    item_valid <= 1'b1;
    operation  <= op;
    reg_index  <= idx;
    reg_value  <= val;
    reg_mask   <= mask;
    flags_in   <= fin;
    do @(posedge clk); while (item_stall);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // mostly well-formed stack traffic with the sp kept near the stack window
  task automatic random_item();
    int pick;
    logic [31:0] val;
    logic [15:0] mask;
    logic [3:0] idx;
    pick = $urandom_range(0, 99);
    idx  = 4'($urandom);
    mask = 16'($urandom);
    val  = $urandom;
    if (pick < 8) begin
      if ($urandom_range(0, 7) != 0) val = $urandom_range(0, 300);
      send_item(rlse_pkg::OP_WRITE, rlse_pkg::SP_REG, val, mask, 4'($urandom));
    end else if (pick < 20) begin
      send_item(rlse_pkg::OP_WRITE, idx, val, mask, 4'($urandom));
    end else if (pick < 33) begin
      send_item(rlse_pkg::OP_READ, idx, val, mask, 4'($urandom));
    end else if (pick < 55) begin
      if ($urandom_range(0, 9) != 0) mask = mask & ~rlse_pkg::PUSH_FORBIDDEN;
      send_item(rlse_pkg::OP_PUSH, idx, val, mask, 4'($urandom));
    end else if (pick < 75) begin
      if ($urandom_range(0, 9) != 0) mask = mask & ~rlse_pkg::POP_FORBIDDEN;
      send_item(rlse_pkg::OP_POP, idx, val, mask, 4'($urandom));
    end else if (pick < 86) begin
      send_item(rlse_pkg::OP_IPUSH, idx, val, mask, 4'($urandom));
    end else if (pick < 97) begin
      send_item(rlse_pkg::OP_IPOP, idx, val, mask, 4'($urandom));
    end else begin
      send_item(3'($urandom), idx, val, mask, 4'($urandom));
    end
  endtask

  // result side: random stall bursts and the one long hold-off
  initial begin : result_side
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // watchdog: too long with no transaction on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    int n;
    int waited;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    operation  <= rlse_pkg::OP_WRITE;
    reg_index  <= '0;
    reg_value  <= '0;
    reg_mask   <= '0;
    flags_in   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed opening
    send_item(rlse_pkg::OP_READ, rlse_pkg::SP_REG, 32'h0, 16'h0, 4'h0);
    send_item(rlse_pkg::OP_WRITE, 4'd0, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
    send_item(rlse_pkg::OP_WRITE, 4'd15, 32'h8000_0001, 16'h0, 4'h0);
    send_item(rlse_pkg::OP_WRITE, 4'd14, 32'h1234_5678, 16'h0, 4'h0);
    // empty list, then a list that runs into the faulting top word
    send_item(rlse_pkg::OP_PUSH, 4'd0, 32'h0, 16'h0000, 4'h0);
    send_item(rlse_pkg::OP_PUSH, 4'd0, 32'h0, 16'h00FF, 4'h0);
    send_item(rlse_pkg::OP_POP, 4'd0, 32'h0, 16'h00FF, 4'h0);
    // forbidden registers in the list
    send_item(rlse_pkg::OP_PUSH, 4'd0, 32'h0, 16'h0100, 4'h0);
    send_item(rlse_pkg::OP_PUSH, 4'd0, 32'h0, 16'h8000, 4'h0);
    send_item(rlse_pkg::OP_POP, 4'd0, 32'h0, 16'h4000, 4'h0);
    send_item(rlse_pkg::OP_POP, 4'd0, 32'h0, 16'h1000, 4'h0);
    // sp at the pre-decrement boundary for both push forms
    send_item(rlse_pkg::OP_WRITE, rlse_pkg::SP_REG, 32'd255, 16'h0, 4'h0);
    send_item(rlse_pkg::OP_IPUSH, 4'd0, 32'h0, 16'h0000, 4'hA);
    send_item(rlse_pkg::OP_WRITE, rlse_pkg::SP_REG, 32'd255, 16'h0, 4'h0);
    send_item(rlse_pkg::OP_PUSH, 4'd0, 32'h0, 16'h4001, 4'h0);
    // full interrupt frames, unaligned addresses
    send_item(rlse_pkg::OP_IPUSH, 4'd0, 32'h0, 16'hFFFF, 4'hF);
    send_item(rlse_pkg::OP_IPOP, 4'd0, 32'h0, 16'hFFFF, 4'h0);
    // flags word lands on the faulting address
    send_item(rlse_pkg::OP_WRITE, rlse_pkg::SP_REG, 32'h0000_00FC, 16'h0, 4'h0);
    send_item(rlse_pkg::OP_IPOP, 4'd0, 32'h0, 16'h0000, 4'h0);
    // pop that loads r13 itself
    send_item(rlse_pkg::OP_POP, 4'd0, 32'h0, 16'h20FF, 4'h0);
    send_item(rlse_pkg::OP_WRITE, rlse_pkg::SP_REG, 32'hFFFF_FFFF, 16'h0, 4'h0);
    send_item(rlse_pkg::OP_PUSH, 4'd0, 32'h0, 16'h0001, 4'h0);
    send_item(OP_SPARE_6, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
    send_item(OP_SPARE_7, 4'd0, 32'h0, 16'h0, 4'h0);
    send_item(rlse_pkg::OP_READ, 4'd15, 32'h0, 16'h0, 4'h0);

    // random traffic; idling switches on and off per stretch
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_gaps = ($urandom_range(0, 3) != 0);
      end
      // long hold-off with the sender pushing hard behind it
      if (n >= 600 && n < 640) begin
        tx_gaps = 1'b0;
        if (n == 600) hold_req = 1'b1;
      end
      if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      random_item();
    end
    item_valid <= 1'b0;

    for (waited = 0; outstanding != 0 && waited < DRAIN_LIMIT; waited++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== register_list_stack_engine.f =====
sv/rlse_pkg.sv
sv/rlse_ram.sv
sv/register_list_stack_engine.sv
test/rlse_checker.sv
test/tb_register_list_stack_engine.sv
